// File: hdl/pidrl_pkg.sv
// ============================================================================
// pidrl_pkg
// Shared types, constants and the microprogram of the ramp limited PID
// controller.
// ============================================================================
`default_nettype none

package pidrl_pkg;

    localparam int Q_BITS_DEFAULT = 15;
    localparam int STEP_SCALE     = 16;
    localparam int RATE_DIV       = 3276;
    localparam int DIV_RADIX      = 4;     // quotient bits per divider cycle
    localparam int REM_W          = 12;    // RATE_DIV - 1 fits
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;
    localparam int PC_W           = 5;

    typedef enum logic [0:0] {
        KIND_STEP  = 1'b0,
        KIND_CLEAR = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP           = 3'd0,
        REG_KI           = 3'd1,
        REG_KD           = 3'd2,
        REG_SLEW_LIMIT   = 3'd3,
        REG_OUTPUT_BOUND = 3'd4
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_MUL,
        OP_ADD,
        OP_SUB,
        OP_CLAMP,
        OP_DIV,
        OP_SLEW,
        OP_OUT,
        OP_CLEAR
    } op_t;

    typedef enum logic [3:0] {
        SRC_KP,
        SRC_KI,
        SRC_KD,
        SRC_SLEW,
        SRC_E,
        SRC_LAST_E,
        SRC_LAST_D,
        SRC_ACC,
        SRC_T,
        SRC_U,
        SRC_I,
        SRC_O,
        SRC_C16,
        SRC_C3276
    } src_t;

    typedef enum logic [1:0] {
        DST_T,
        DST_U,
        DST_I,
        DST_O
    } dst_t;

    typedef enum logic [1:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_CLEAR,
        JC_NO_SLEW
    } jc_t;

    typedef struct packed {
        op_t             op;
        src_t            a;
        src_t            b;
        dst_t            dst;
        jc_t             jc;
        logic [PC_W-1:0] target;
    } ctrl_t;

    localparam logic [PC_W-1:0] PC_START = 5'd0;
    localparam logic [PC_W-1:0] PC_OUT   = 5'd17;
    localparam logic [PC_W-1:0] PC_CLR   = 5'd18;

    function automatic ctrl_t cw(input op_t op, input src_t a, input src_t b,
                                 input dst_t dst, input jc_t jc,
                                 input logic [PC_W-1:0] target);
        ctrl_t c;
        c.op     = op;
        c.a      = a;
        c.b      = b;
        c.dst    = dst;
        c.jc     = jc;
        c.target = target;
        return c;
    endfunction

    // t, u: scratch; i: new integral; o: new drive
    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t c;
        case (pc)
            5'd0:    c = cw(OP_NOP,   SRC_E,      SRC_E,      DST_T, JC_CLEAR,   PC_CLR);
            5'd1:    c = cw(OP_MUL,   SRC_KI,     SRC_C16,    DST_T, JC_NEXT,    PC_START);
            5'd2:    c = cw(OP_ADD,   SRC_E,      SRC_LAST_E, DST_U, JC_NEXT,    PC_START);
            5'd3:    c = cw(OP_MUL,   SRC_T,      SRC_U,      DST_T, JC_NEXT,    PC_START);
            5'd4:    c = cw(OP_ADD,   SRC_ACC,    SRC_T,      DST_I, JC_NEXT,    PC_START);
            5'd5:    c = cw(OP_CLAMP, SRC_I,      SRC_I,      DST_I, JC_NEXT,    PC_START);
            5'd6:    c = cw(OP_SUB,   SRC_E,      SRC_LAST_E, DST_U, JC_NEXT,    PC_START);
            5'd7:    c = cw(OP_MUL,   SRC_KD,     SRC_U,      DST_U, JC_NEXT,    PC_START);
            5'd8:    c = cw(OP_DIV,   SRC_U,      SRC_U,      DST_U, JC_NEXT,    PC_START);
            5'd9:    c = cw(OP_MUL,   SRC_KP,     SRC_E,      DST_T, JC_NEXT,    PC_START);
            5'd10:   c = cw(OP_ADD,   SRC_T,      SRC_I,      DST_T, JC_NEXT,    PC_START);
            5'd11:   c = cw(OP_ADD,   SRC_T,      SRC_U,      DST_T, JC_NEXT,    PC_START);
            5'd12:   c = cw(OP_CLAMP, SRC_T,      SRC_T,      DST_O, JC_NO_SLEW, PC_OUT);
            5'd13:   c = cw(OP_SUB,   SRC_O,      SRC_LAST_D, DST_U, JC_NEXT,    PC_START);
            5'd14:   c = cw(OP_DIV,   SRC_U,      SRC_U,      DST_U, JC_NEXT,    PC_START);
            5'd15:   c = cw(OP_MUL,   SRC_SLEW,   SRC_C3276,  DST_T, JC_NEXT,    PC_START);
            5'd16:   c = cw(OP_SLEW,  SRC_LAST_D, SRC_T,      DST_O, JC_NEXT,    PC_START);
            5'd17:   c = cw(OP_OUT,   SRC_O,      SRC_O,      DST_O, JC_ALWAYS,  PC_START);
            5'd18:   c = cw(OP_CLEAR, SRC_O,      SRC_O,      DST_O, JC_ALWAYS,  PC_OUT);
            default: c = cw(OP_NOP,   SRC_O,      SRC_O,      DST_O, JC_ALWAYS,  PC_OUT);
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hdl/pidrl_sample_if.sv
// ============================================================================
// pidrl_sample_if
// Request channel of the controller: step with error sample, or clear.
// ============================================================================
`default_nettype none

interface pidrl_sample_if;
    logic                  valid;
    logic                  ready;
    pidrl_pkg::kind_t      kind;
    logic signed [31:0]    error_sample;

    modport source (output valid, output kind, output error_sample, input ready);
    modport sink   (input valid, input kind, input error_sample, output ready);
endinterface

`default_nettype wire

// File: hdl/pidrl_result_if.sv
// ============================================================================
// pidrl_result_if
// Result channel of the controller: one drive value per request.
// ============================================================================
`default_nettype none

interface pidrl_result_if;
    logic                  valid;
    logic                  ready;
    logic signed [31:0]    drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

`default_nettype wire

// File: hdl/pid_ramp_limited_controller.sv
// ============================================================================
// pid_ramp_limited_controller
// Discrete PID with trapezoidal integral, output clamp and slew limit, run
// by a microprogram over one multiplier, one adder and a radix-16 divider.
// ============================================================================
//
//  channel   dir   handshake        payload
//  sample    in    valid / ready    kind, error_sample
//  result    out   valid / ready    drive
//  cfg       in    cfg_we           cfg_index, cfg_data
//
//  One request at a time. A step runs two serial divides by 3276, one with
//  slew limit off; a clear runs none.
//  Ready is high whenever the sequencer is idle, also while a result waits.
//  The last step holds while the result register is full and not taken.
//  Reset clears gains, bounds and the integral/drive/error state.
// ============================================================================
`default_nettype none

module pid_ramp_limited_controller #(
    parameter int Q_BITS = pidrl_pkg::Q_BITS_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    pidrl_sample_if.sink                          sample,
    pidrl_result_if.source                        result,
    input  wire logic                             cfg_we,
    input  wire logic [pidrl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pidrl_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int DIV_W     = 32 + Q_BITS;
    localparam int DIV_STEPS = (DIV_W + pidrl_pkg::DIV_RADIX - 1) / pidrl_pkg::DIV_RADIX;
    localparam int DIV_PAD   = DIV_STEPS * pidrl_pkg::DIV_RADIX;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int REM_W     = pidrl_pkg::REM_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    // control
    state_t                          state_reg, state_next;
    logic [pidrl_pkg::PC_W-1:0]      pc_reg, pc_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            div_busy_reg, div_busy_next;
    logic                            div_done_reg, div_done_next;
    logic [CNT_W-1:0]                div_cnt_reg, div_cnt_next;

    // configuration and loop state
    logic signed [31:0]              kp_reg, kp_next;
    logic signed [31:0]              ki_reg, ki_next;
    logic signed [31:0]              kd_reg, kd_next;
    logic [30:0]                     slew_reg, slew_next;
    logic [30:0]                     bound_reg, bound_next;
    logic signed [31:0]              acc_reg, acc_next;
    logic signed [31:0]              last_d_reg, last_d_next;
    logic signed [31:0]              last_e_reg, last_e_next;

    // datapath
    pidrl_pkg::kind_t                kind_reg, kind_next;
    logic signed [31:0]              e_reg, e_next;
    logic signed [31:0]              t_reg, t_next;
    logic signed [31:0]              u_reg, u_next;
    logic signed [31:0]              i_reg, i_next;
    logic signed [31:0]              o_reg, o_next;
    logic signed [31:0]              drive_reg, drive_next;
    logic [DIV_PAD-1:0]              div_num_reg, div_num_next;
    logic [REM_W-1:0]                div_rem_reg, div_rem_next;
    logic [31:0]                     div_quo_reg, div_quo_next;
    logic                            div_neg_reg, div_neg_next;

    pidrl_pkg::ctrl_t                ctrl;
    logic signed [31:0]              op_a;
    logic signed [31:0]              op_b;
    logic signed [63:0]              prod;
    logic signed [31:0]              qmul_res;
    logic signed [31:0]              bound_pos;
    logic signed [31:0]              bound_neg;
    logic signed [31:0]              slew_pos;
    logic signed [31:0]              slew_neg;
    logic signed [31:0]              clamp_res;
    logic signed [31:0]              slew_res;
    logic signed [31:0]              div_res;
    logic signed [31:0]              alu_res;
    logic [31:0]                     div_mag;
    logic [REM_W-1:0]                iter_rem;
    logic [31:0]                     iter_quo;
    logic                            accept;
    logic                            out_free;
    logic                            step_done;
    logic                            jump_take;
    logic                            wr_en;

    assign accept        = sample.valid && sample.ready;
    assign sample.ready  = (state_reg == ST_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.drive  = drive_reg;
    assign out_free      = !out_valid_reg || result.ready;

    assign ctrl = pidrl_pkg::ucode(pc_reg);

    always_comb
    begin
        case (ctrl.a)
            pidrl_pkg::SRC_KP:     op_a = kp_reg;
            pidrl_pkg::SRC_KI:     op_a = ki_reg;
            pidrl_pkg::SRC_KD:     op_a = kd_reg;
            pidrl_pkg::SRC_SLEW:   op_a = {1'b0, slew_reg};
            pidrl_pkg::SRC_E:      op_a = e_reg;
            pidrl_pkg::SRC_LAST_E: op_a = last_e_reg;
            pidrl_pkg::SRC_LAST_D: op_a = last_d_reg;
            pidrl_pkg::SRC_ACC:    op_a = acc_reg;
            pidrl_pkg::SRC_T:      op_a = t_reg;
            pidrl_pkg::SRC_U:      op_a = u_reg;
            pidrl_pkg::SRC_I:      op_a = i_reg;
            pidrl_pkg::SRC_O:      op_a = o_reg;
            pidrl_pkg::SRC_C16:    op_a = 32'(pidrl_pkg::STEP_SCALE);
            pidrl_pkg::SRC_C3276:  op_a = 32'(pidrl_pkg::RATE_DIV);
            default:               op_a = '0;
        endcase
    end

    always_comb
    begin
        case (ctrl.b)
            pidrl_pkg::SRC_KP:     op_b = kp_reg;
            pidrl_pkg::SRC_KI:     op_b = ki_reg;
            pidrl_pkg::SRC_KD:     op_b = kd_reg;
            pidrl_pkg::SRC_SLEW:   op_b = {1'b0, slew_reg};
            pidrl_pkg::SRC_E:      op_b = e_reg;
            pidrl_pkg::SRC_LAST_E: op_b = last_e_reg;
            pidrl_pkg::SRC_LAST_D: op_b = last_d_reg;
            pidrl_pkg::SRC_ACC:    op_b = acc_reg;
            pidrl_pkg::SRC_T:      op_b = t_reg;
            pidrl_pkg::SRC_U:      op_b = u_reg;
            pidrl_pkg::SRC_I:      op_b = i_reg;
            pidrl_pkg::SRC_O:      op_b = o_reg;
            pidrl_pkg::SRC_C16:    op_b = 32'(pidrl_pkg::STEP_SCALE);
            pidrl_pkg::SRC_C3276:  op_b = 32'(pidrl_pkg::RATE_DIV);
            default:               op_b = '0;
        endcase
    end

    // 32x32 signed product, Q shift by bit select
    assign prod     = op_a * op_b;
    assign qmul_res = prod[Q_BITS+31:Q_BITS];

    assign bound_pos = {1'b0, bound_reg};
    assign bound_neg = -bound_pos;
    assign slew_pos  = {1'b0, slew_reg};
    assign slew_neg  = -slew_pos;

    always_comb
    begin
        if (op_a < bound_neg)
            clamp_res = bound_neg;
        else if (op_a > bound_pos)
            clamp_res = bound_pos;
        else
            clamp_res = op_a;
    end

    // u holds the rate, a = last drive, b = slew step
    always_comb
    begin
        if (u_reg > slew_pos)
            slew_res = op_a + op_b;
        else if (u_reg < slew_neg)
            slew_res = op_a - op_b;
        else
            slew_res = o_reg;
    end

    assign div_res = div_neg_reg ? -$signed(div_quo_reg) : $signed(div_quo_reg);
    assign div_mag = op_a[31] ? 32'(-op_a) : 32'(op_a);

    always_comb
    begin
        case (ctrl.op)
            pidrl_pkg::OP_MUL:   alu_res = qmul_res;
            pidrl_pkg::OP_ADD:   alu_res = op_a + op_b;
            pidrl_pkg::OP_SUB:   alu_res = op_a - op_b;
            pidrl_pkg::OP_CLAMP: alu_res = clamp_res;
            pidrl_pkg::OP_DIV:   alu_res = div_res;
            pidrl_pkg::OP_SLEW:  alu_res = slew_res;
            default:             alu_res = '0;
        endcase
    end

    // restoring division by 3276, four quotient bits per cycle
    always_comb
    begin
        logic [REM_W:0] trial;
        iter_rem = div_rem_reg;
        iter_quo = div_quo_reg;
        for (int k = 0; k < pidrl_pkg::DIV_RADIX; k++)
        begin
            trial = {iter_rem, div_num_reg[DIV_PAD-1-k]};
            if (trial >= (REM_W+1)'(pidrl_pkg::RATE_DIV))
            begin
                iter_rem = REM_W'(trial - (REM_W+1)'(pidrl_pkg::RATE_DIV));
                iter_quo = {iter_quo[30:0], 1'b1};
            end
            else
            begin
                iter_rem = trial[REM_W-1:0];
                iter_quo = {iter_quo[30:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        case (ctrl.op)
            pidrl_pkg::OP_DIV: step_done = div_done_reg;
            pidrl_pkg::OP_OUT: step_done = out_free;
            default:           step_done = 1'b1;
        endcase
    end

    always_comb
    begin
        case (ctrl.jc)
            pidrl_pkg::JC_ALWAYS:  jump_take = 1'b1;
            pidrl_pkg::JC_CLEAR:   jump_take = (kind_reg == pidrl_pkg::KIND_CLEAR);
            pidrl_pkg::JC_NO_SLEW: jump_take = (slew_reg == '0);
            default:               jump_take = 1'b0;
        endcase
    end

    assign wr_en = (state_reg == ST_RUN) && step_done &&
                   (ctrl.op == pidrl_pkg::OP_MUL   || ctrl.op == pidrl_pkg::OP_ADD  ||
                    ctrl.op == pidrl_pkg::OP_SUB   || ctrl.op == pidrl_pkg::OP_CLAMP ||
                    ctrl.op == pidrl_pkg::OP_DIV   || ctrl.op == pidrl_pkg::OP_SLEW);

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg;
        div_busy_next  = div_busy_reg;
        div_done_next  = div_done_reg;
        div_cnt_next   = div_cnt_reg;
        kp_next        = kp_reg;
        ki_next        = ki_reg;
        kd_next        = kd_reg;
        slew_next      = slew_reg;
        bound_next     = bound_reg;
        acc_next       = acc_reg;
        last_d_next    = last_d_reg;
        last_e_next    = last_e_reg;
        kind_next      = kind_reg;
        e_next         = e_reg;
        t_next         = t_reg;
        u_next         = u_reg;
        i_next         = i_reg;
        o_next         = o_reg;
        drive_next     = drive_reg;
        div_num_next   = div_num_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        div_neg_next   = div_neg_reg;

        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                pidrl_pkg::REG_KP:           kp_next    = $signed(cfg_data[31:0]);
                pidrl_pkg::REG_KI:           ki_next    = $signed(cfg_data[31:0]);
                pidrl_pkg::REG_KD:           kd_next    = $signed(cfg_data[31:0]);
                pidrl_pkg::REG_SLEW_LIMIT:   slew_next  = cfg_data[30:0];
                pidrl_pkg::REG_OUTPUT_BOUND: bound_next = cfg_data[30:0];
                default:                     ;
            endcase
        end

        if (accept)
        begin
            state_next = ST_RUN;
            pc_next    = pidrl_pkg::PC_START;
            kind_next  = sample.kind;
            e_next     = sample.error_sample;
        end

        if (div_busy_reg)
        begin
            div_num_next = div_num_reg << pidrl_pkg::DIV_RADIX;
            div_rem_next = iter_rem;
            div_quo_next = iter_quo;
            div_cnt_next = div_cnt_reg - CNT_W'(1);
            if (div_cnt_reg == CNT_W'(1))
            begin
                div_busy_next = 1'b0;
                div_done_next = 1'b1;
            end
        end

        if (state_reg == ST_RUN)
        begin
            if (ctrl.op == pidrl_pkg::OP_DIV && !div_busy_reg && !div_done_reg)
            begin
                div_busy_next = 1'b1;
                div_cnt_next  = CNT_W'(DIV_STEPS);
                div_neg_next  = op_a[31];
                div_num_next  = DIV_PAD'(div_mag) << Q_BITS;
                div_rem_next  = '0;
                div_quo_next  = '0;
            end
            if (ctrl.op == pidrl_pkg::OP_DIV && div_done_reg)
                div_done_next = 1'b0;

            if (ctrl.op == pidrl_pkg::OP_CLEAR)
            begin
                i_next = '0;
                o_next = '0;
                e_next = '0;
            end

            if (wr_en)
            begin
                case (ctrl.dst)
                    pidrl_pkg::DST_T: t_next = alu_res;
                    pidrl_pkg::DST_U: u_next = alu_res;
                    pidrl_pkg::DST_I: i_next = alu_res;
                    pidrl_pkg::DST_O: o_next = alu_res;
                    default:          ;
                endcase
            end

            if (ctrl.op == pidrl_pkg::OP_OUT && out_free)
            begin
                drive_next     = o_reg;
                out_valid_next = 1'b1;
                acc_next       = i_reg;
                last_d_next    = o_reg;
                last_e_next    = e_reg;
                state_next     = ST_IDLE;
            end

            if (step_done)
                pc_next = jump_take ? ctrl.target : pc_reg + pidrl_pkg::PC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= pidrl_pkg::PC_START;
            out_valid_reg <= 1'b0;
            div_busy_reg  <= 1'b0;
            div_done_reg  <= 1'b0;
            div_cnt_reg   <= '0;
            kp_reg        <= '0;
            ki_reg        <= '0;
            kd_reg        <= '0;
            slew_reg      <= '0;
            bound_reg     <= '0;
            acc_reg       <= '0;
            last_d_reg    <= '0;
            last_e_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            div_busy_reg  <= div_busy_next;
            div_done_reg  <= div_done_next;
            div_cnt_reg   <= div_cnt_next;
            kp_reg        <= kp_next;
            ki_reg        <= ki_next;
            kd_reg        <= kd_next;
            slew_reg      <= slew_next;
            bound_reg     <= bound_next;
            acc_reg       <= acc_next;
            last_d_reg    <= last_d_next;
            last_e_reg    <= last_e_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        e_reg       <= e_next;
        t_reg       <= t_next;
        u_reg       <= u_next;
        i_reg       <= i_next;
        o_reg       <= o_next;
        drive_reg   <= drive_next;
        div_num_reg <= div_num_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        div_neg_reg <= div_neg_next;
    end

endmodule

`default_nettype wire

// File: dv/pid_ramp_limited_controller_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// pid_ramp_limited_controller_tb
// Self-checking bench for the ramp limited PID controller. Requests (steps
// and clears) go in over the sample channel with random gaps; drive values
// come back with random result stalls and are compared against an in-bench
// fixed-point model of the controller, including integral/output clamping,
// slew limiting and 32-bit wraparound. Registers are reprogrammed between
// phases while the controller is idle.
// ============================================================================

module pid_ramp_limited_controller_tb;
    import pidrl_pkg::*;

    typedef logic signed [31:0] q_t;

    localparam int  Q_BITS     = Q_BITS_DEFAULT;
    localparam q_t  Q_MAX      = 32'sh7fffffff;
    localparam q_t  Q_MIN      = 32'sh80000000;
    localparam q_t  Q_ONE      = q_t'(1) <<< Q_BITS;
    localparam int  RAND_ITEMS = 930;
    localparam int  SETTLE_CYC = 60;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pidrl_sample_if sample_ch ();
    pidrl_result_if result_ch ();

    pid_ramp_limited_controller u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model state and registers
    q_t          gain_p, gain_i, gain_d;
    logic [30:0] slew_max, out_bound;
    q_t          acc_integral, prev_drive, prev_error;

    q_t drive_expected[$];
    bit idle_on;
    int n_errors, n_checked, n_steps, n_clears, n_settings;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic q_t q_mul(q_t a, q_t b);
        longint prod;
        prod = (longint'(a) * longint'(b)) >>> Q_BITS;
        return prod[31:0];
    endfunction

    function automatic q_t q_div(q_t x);
        longint quo;
        quo = (longint'(x) <<< Q_BITS) / longint'(RATE_DIV);
        return quo[31:0];
    endfunction

    function automatic q_t clamp_bound(q_t v, logic [30:0] b);
        q_t lim;
        lim = q_t'({1'b0, b});
        if (v < -lim)
            return -lim;
        if (v > lim)
            return lim;
        return v;
    endfunction

    function automatic q_t next_drive(kind_t k, q_t e);
        q_t p, i, d, o, rate, lim;
        if (k == KIND_CLEAR)
        begin
            acc_integral = '0;
            prev_drive   = '0;
            prev_error   = '0;
            return '0;
        end
        p = q_mul(gain_p, e);
        i = clamp_bound(acc_integral + q_mul(q_mul(gain_i, STEP_SCALE), e + prev_error),
                        out_bound);
        d = q_div(q_mul(gain_d, e - prev_error));
        o = clamp_bound(p + i + d, out_bound);
        if (slew_max != '0)
        begin
            lim  = q_t'({1'b0, slew_max});
            rate = q_div(o - prev_drive);
            if (rate > lim)
                o = prev_drive + q_mul(lim, RATE_DIV);
            else if (rate < -lim)
                o = prev_drive - q_mul(lim, RATE_DIV);
        end
        acc_integral = i;
        prev_drive   = o;
        prev_error   = e;
        return o;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_KP:           gain_p    = data;
            REG_KI:           gain_i    = data;
            REG_KD:           gain_d    = data;
            REG_SLEW_LIMIT:   slew_max  = data[30:0];
            REG_OUTPUT_BOUND: out_bound = data[30:0];
            default: ;
        endcase
    endtask

    task automatic set_gains(q_t kp, q_t ki, q_t kd, logic [31:0] slew, logic [31:0] bound);
        write_reg(REG_KP, kp);
        write_reg(REG_KI, ki);
        write_reg(REG_KD, kd);
        write_reg(REG_SLEW_LIMIT, slew);
        write_reg(REG_OUTPUT_BOUND, bound);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic send_request(kind_t k, q_t e);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.kind         <= k;
        sample_ch.error_sample <= e;
        do @(posedge clk); while (!sample_ch.ready);
        drive_expected.push_back(next_drive(k, e));
        if (k == KIND_CLEAR)
            n_clears++;
        else
            n_steps++;
    endtask

    // stop sending and wait for every outstanding drive value
    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        while (drive_expected.size() != 0)
            @(posedge clk);
    endtask

    function automatic q_t rand_error();
        case ($urandom_range(0, 9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return q_t'($urandom_range(0, 2)) - 1;
            3, 4, 5: return q_t'($urandom_range(0, 131071)) - 65536;
            default: return q_t'($urandom);
        endcase
    endfunction

    function automatic q_t rand_gain();
        case ($urandom_range(0, 9))
            0:          return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
            1:          return '0;
            2, 3, 4, 5: return q_t'($urandom_range(0, 1 << 19)) - (1 << 18);
            default:    return q_t'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_slew();
        case ($urandom_range(0, 9))
            0, 1, 2: return {$urandom_range(0, 1) == 1, 31'd0};
            3:       return 32'd1;
            4:       return {$urandom_range(0, 1) == 1, 31'h7fffffff};
            5, 6, 7: return $urandom_range(1, 1 << 16);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_bound();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return {$urandom_range(0, 1) == 1, 31'h7fffffff};
            2, 3, 4: return $urandom_range(0, 1 << 20);
            default: return $urandom;
        endcase
    endfunction

    // result side: random stall before each accept
    initial begin
        int stall;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        q_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (drive_expected.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: unexpected drive %0d (0x%08h)",
                             result_ch.drive, result_ch.drive);
            end
            else
            begin
                want = drive_expected.pop_front();
                n_checked++;
                if (result_ch.drive !== want)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: drive mismatch, expected 0x%08h got 0x%08h",
                                 want, result_ch.drive);
                end
            end
        end
    end

    // registers still at reset: everything drives zero
    task automatic test_reset_state();
        send_request(KIND_STEP, Q_MAX);
        send_request(KIND_STEP, Q_MIN);
        send_request(KIND_STEP, -1);
        wait_idle();
    endtask

    task automatic test_zero_bound();
        set_gains(Q_MAX, Q_ONE, -Q_ONE, 32'd0, 32'h80000000);
        send_request(KIND_STEP, 12345);
        send_request(KIND_STEP, Q_MIN);
        wait_idle();
    endtask

    task automatic test_unused_index();
        for (int r = int'(REG_OUTPUT_BOUND) + 1; r < (1 << CFG_IDX_W); r++)
            write_reg(r[CFG_IDX_W-1:0], 32'hffffffff);
        cfg_we <= 1'b0;
        send_request(KIND_STEP, Q_MAX);
        wait_idle();
    endtask

    task automatic test_clamp_and_wrap();
        set_gains(Q_MAX, Q_MAX, Q_MIN, 32'd0, 32'h7fffffff);
        send_request(KIND_STEP, Q_MAX);
        send_request(KIND_STEP, Q_MIN);
        send_request(KIND_STEP, Q_MAX);
        send_request(KIND_STEP, 0);
        send_request(KIND_STEP, -1);
        send_request(KIND_CLEAR, Q_MAX);
        send_request(KIND_STEP, Q_MAX);
        wait_idle();
    endtask

    task automatic test_slew_limit();
        set_gains(Q_ONE, '0, '0, 32'd1, 32'h7fffffff);
        send_request(KIND_STEP, 1000000);
        send_request(KIND_STEP, -1000000);
        send_request(KIND_STEP, Q_MAX);
        send_request(KIND_STEP, Q_MIN);
        wait_idle();
        set_gains(Q_ONE, '0, '0, 32'h7fffffff, 32'h7fffffff);
        send_request(KIND_STEP, Q_MAX);
        send_request(KIND_STEP, Q_MIN);
        send_request(KIND_CLEAR, '0);
        wait_idle();
    endtask

    // phases of random settings; most phases feed a slowly moving error
    task automatic test_random_control(int target);
        int sent, run_len;
        bit smooth;
        q_t walk;
        sent = 0;
        while (sent < target)
        begin
            set_gains(rand_gain(), rand_gain(), rand_gain(), rand_slew(), rand_bound());
            idle_on = ($urandom_range(0, 3) != 0);
            smooth  = ($urandom_range(0, 4) < 3);
            walk    = rand_error();
            run_len = $urandom_range(40, 100);
            for (int n = 0; n < run_len && sent < target; n++)
            begin
                if ($urandom_range(0, 99) < 4)
                    send_request(KIND_CLEAR, q_t'($urandom));
                else if (smooth)
                begin
                    walk = walk + q_t'($urandom_range(0, 8191)) - 4096;
                    send_request(KIND_STEP, walk);
                end
                else
                    send_request(KIND_STEP, rand_error());
                sent++;
            end
            wait_idle();
        end
    endtask

    initial begin
        n_errors   = 0;
        n_checked  = 0;
        n_steps    = 0;
        n_clears   = 0;
        n_settings = 0;
        idle_on    = 1'b1;
        gain_p = '0; gain_i = '0; gain_d = '0;
        slew_max = '0; out_bound = '0;
        acc_integral = '0; prev_drive = '0; prev_error = '0;
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= '0;
        cfg_data               <= '0;
        sample_ch.valid        <= 1'b0;
        sample_ch.kind         <= KIND_STEP;
        sample_ch.error_sample <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_zero_bound();
        test_unused_index();
        test_clamp_and_wrap();
        test_slew_limit();
        test_random_control(RAND_ITEMS);

        repeat (SETTLE_CYC) @(posedge clk);
        $display("Covered %0d control steps and %0d clears under %0d register settings.",
                 n_steps, n_clears, n_settings);
        $display("Compared %0d drive values, %0d errors.", n_checked, n_errors);
        if (n_errors == 0 && drive_expected.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
